@@ src/fcw_pkg.sv @@
// fcw_pkg: shared widths, codes and types for the fat12 chain walker
// no dependencies
`default_nettype none
package fcw_pkg;

  localparam int ADDR_W = 13;
  localparam int DATA_W = 8;
  localparam int CL_W   = 12;
  localparam int KIND_W = 2;

  localparam int TABLE_BYTES_DEF = 8192;
  localparam int MAX_CHAIN_DEF   = 64;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_FOLLOW = 1'b1;

  localparam logic [CL_W-1:0] CL_MIN  = 12'h002;
  localparam logic [CL_W-1:0] CL_MAX  = 12'hFEF;
  localparam logic [CL_W-1:0] EOC_MIN = 12'hFF8;

  localparam logic [KIND_W-1:0] KIND_EOC = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BAD = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CAP = 2'd2;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  // byte offset of entry n: n + n/2
  function automatic logic [ADDR_W-1:0] entry_off(input logic [CL_W-1:0] n);
    entry_off = {1'b0, n} + {2'b00, n[CL_W-1:1]};
  endfunction

endpackage
`default_nettype wire

@@ src/fcw_table.sv @@
// fcw_table: byte-wide allocation table memory, one port, registered read
// depends on fcw_pkg; out-of-range bytes read as zero, writes beyond are dropped
`default_nettype none
module fcw_table #(
  parameter int TABLE_BYTES = fcw_pkg::TABLE_BYTES_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire fcw_pkg::mem_req_t        req_i,
  output logic [fcw_pkg::DATA_W-1:0]    rdata_o
);
  import fcw_pkg::*;

  localparam int AW = $clog2(TABLE_BYTES);

  logic [DATA_W-1:0] mem_q [TABLE_BYTES];
  logic [DATA_W-1:0] rd_q;
  logic              zero_q;
  logic              w_in;
  logic              r_in;

  assign w_in = int'(req_i.waddr) < TABLE_BYTES;
  assign r_in = int'(req_i.raddr) < TABLE_BYTES;

  always_ff @(posedge clk_i) begin
    if (req_i.we && w_in) begin
      mem_q[req_i.waddr[AW-1:0]] <= req_i.wdata;
    end
    if (req_i.re && r_in) begin
      rd_q <= mem_q[req_i.raddr[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_q <= 1'b1;
    end else if (req_i.re) begin
      zero_q <= !r_in;
    end
  end

  assign rdata_o = zero_q ? '0 : rd_q;

endmodule
`default_nettype wire

@@ src/fcw_walker.sv @@
// fcw_walker: request decode and chain sequencer, two table reads per link
// depends on fcw_pkg; drives fcw_table through a mem_req_t
`default_nettype none
module fcw_walker #(
  parameter int MAX_CHAIN = fcw_pkg::MAX_CHAIN_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic                      cmd_i,
  input  wire logic [fcw_pkg::ADDR_W-1:0] byte_addr_i,
  input  wire logic [fcw_pkg::DATA_W-1:0] byte_value_i,
  input  wire logic [fcw_pkg::CL_W-1:0]   start_cluster_i,
  output logic                           busy_o,
  output logic                           strobe_o,
  output logic [fcw_pkg::CL_W-1:0]        cluster_o,
  output logic                           last_o,
  output logic [fcw_pkg::KIND_W-1:0]      end_kind_o,
  output fcw_pkg::mem_req_t              req_o,
  input  wire logic [fcw_pkg::DATA_W-1:0] rdata_i
);
  import fcw_pkg::*;

  localparam int CW = $clog2(MAX_CHAIN);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD_HI,
    S_EVAL
  } state_e;

  state_e            state_q;
  logic [CL_W-1:0]   cur_q;
  logic [ADDR_W-1:0] off_q;
  logic [DATA_W-1:0] lo_q;
  logic [CW-1:0]     count_q;
  logic              strobe_q;
  logic [CL_W-1:0]   cluster_q;
  logic              last_q;
  logic [KIND_W-1:0] kind_q;

  logic [CL_W-1:0]   entry;
  logic              cont;
  logic              go_on;
  logic              accept;

  assign accept = start_i && (state_q == S_IDLE);
  assign entry  = cur_q[0] ? {rdata_i, lo_q[7:4]} : {rdata_i[3:0], lo_q};
  assign cont   = (entry >= CL_MIN) && (entry <= CL_MAX);
  assign go_on  = cont && (count_q != CW'(MAX_CHAIN - 1));

  always_comb begin
    req_o = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept && cmd_i == CMD_WRITE) begin
          req_o.we    = 1'b1;
          req_o.waddr = byte_addr_i;
          req_o.wdata = byte_value_i;
        end else if (accept) begin
          req_o.re    = 1'b1;
          req_o.raddr = entry_off(start_cluster_i);
        end
      end
      S_RD_HI: begin
        req_o.re    = 1'b1;
        req_o.raddr = off_q + ADDR_W'(1);
      end
      S_EVAL: begin
        if (go_on) begin
          req_o.re    = 1'b1;
          req_o.raddr = entry_off(entry);
        end
      end
      default: req_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cur_q     <= '0;
      off_q     <= '0;
      count_q   <= '0;
      strobe_q  <= 1'b0;
      cluster_q <= '0;
      last_q    <= 1'b0;
      kind_q    <= KIND_EOC;
      lo_q      <= '0;
    end else begin
      strobe_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept && cmd_i == CMD_FOLLOW) begin
            cur_q   <= start_cluster_i;
            off_q   <= entry_off(start_cluster_i);
            count_q <= '0;
            state_q <= S_RD_HI;
          end
        end
        S_RD_HI: begin
          lo_q    <= rdata_i;
          state_q <= S_EVAL;
        end
        S_EVAL: begin
          strobe_q  <= 1'b1;
          cluster_q <= cur_q;
          last_q    <= !go_on;
          if (go_on) begin
            kind_q  <= KIND_EOC;
            cur_q   <= entry;
            off_q   <= entry_off(entry);
            count_q <= count_q + CW'(1);
            state_q <= S_RD_HI;
          end else begin
            if (entry >= EOC_MIN) begin
              kind_q <= KIND_EOC;
            end else if (!cont) begin
              kind_q <= KIND_BAD;
            end else begin
              kind_q <= KIND_CAP;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o     = (state_q != S_IDLE);
  assign strobe_o   = strobe_q;
  assign cluster_o  = cluster_q;
  assign last_o     = last_q;
  assign end_kind_o = kind_q;

endmodule
`default_nettype wire

@@ src/fat12_cluster_chain_walker_core.sv @@
// fat12_cluster_chain_walker_core: top level, table memory plus chain sequencer
// depends on fcw_pkg, fcw_table, fcw_walker
// a write request gives no result; busy stays low
// a follow request gives one result per link, each after two byte reads of the single
// table port (low byte, then high byte); busy falls as the last result is shown
// results cannot be stalled; reset clears control state only, table contents are undefined
`default_nettype none
module fat12_cluster_chain_walker_core #(
  parameter int TABLE_BYTES = fcw_pkg::TABLE_BYTES_DEF,
  parameter int MAX_CHAIN   = fcw_pkg::MAX_CHAIN_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic                       cmd_i,
  input  wire logic [fcw_pkg::ADDR_W-1:0] byte_addr_i,
  input  wire logic [fcw_pkg::DATA_W-1:0] byte_value_i,
  input  wire logic [fcw_pkg::CL_W-1:0]   start_cluster_i,
  output logic                            strobe,
  output logic [fcw_pkg::CL_W-1:0]        cluster_o,
  output logic                            last_o,
  output logic [fcw_pkg::KIND_W-1:0]      end_kind_o
);
  import fcw_pkg::*;

  mem_req_t          req;
  logic [DATA_W-1:0] rdata;

  fcw_table #(
    .TABLE_BYTES(TABLE_BYTES)
  ) u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rdata_o(rdata)
  );

  fcw_walker #(
    .MAX_CHAIN(MAX_CHAIN)
  ) u_walker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .cmd_i          (cmd_i),
    .byte_addr_i    (byte_addr_i),
    .byte_value_i   (byte_value_i),
    .start_cluster_i(start_cluster_i),
    .busy_o         (busy),
    .strobe_o       (strobe),
    .cluster_o      (cluster_o),
    .last_o         (last_o),
    .end_kind_o     (end_kind_o),
    .req_o          (req),
    .rdata_i        (rdata)
  );

  a_busy_from_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start && cmd_i == CMD_FOLLOW))
    else $error("busy rose without a follow request");

  a_last_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe && last_o |-> !busy)
    else $error("walker still busy after last result");

  a_mid_keeps_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe && !last_o |-> busy && end_kind_o == KIND_EOC)
    else $error("non-last result outside a walk");

  a_no_table_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req.we && req.re))
    else $error("table read and write in the same cycle");

endmodule
`default_nettype wire

@@ sim/fat12_cluster_chain_walker_core_test.sv @@
// fat12_cluster_chain_walker_core_test: self-checking regression for the fat12 chain walker
// builds cluster chains in the allocation table with byte writes, follows them and checks each
// emitted cluster against a shadow table walk; depends on fcw_pkg and fat12_cluster_chain_walker_core
`default_nettype none
module fat12_cluster_chain_walker_core_test;
  import fcw_pkg::*;

  localparam int CHAIN_CAP       = MAX_CHAIN_DEF;
  localparam int TBL_BYTES       = TABLE_BYTES_DEF;
  localparam int CYCLE_LIMIT     = 900000;
  localparam int RANDOM_REQUESTS = 170;

  typedef enum int {TAIL_EOC, TAIL_BAD, TAIL_LOOP} tail_e;

  typedef struct {
    logic [CL_W-1:0]   cluster;
    logic              is_last;
    logic [KIND_W-1:0] kind;
  } link_t;

  logic              clk_i           = 1'b0;
  logic              rst_ni          = 1'b0;
  logic              start           = 1'b0;
  logic              cmd_i           = CMD_WRITE;
  logic [ADDR_W-1:0] byte_addr_i     = '0;
  logic [DATA_W-1:0] byte_value_i    = '0;
  logic [CL_W-1:0]   start_cluster_i = '0;
  logic              busy;
  logic              strobe;
  logic [CL_W-1:0]   cluster_o;
  logic              last_o;
  logic [KIND_W-1:0] end_kind_o;

  logic [DATA_W-1:0] fat_img [TBL_BYTES];
  bit                fat_known [TBL_BYTES];
  link_t             chain_q [$];
  int                n_errors   = 0;
  int                n_requests = 0;
  int                n_cycles   = 0;
  int                gap_pct    = 21;

  fat12_cluster_chain_walker_core u_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .cmd_i(cmd_i),
    .byte_addr_i(byte_addr_i),
    .byte_value_i(byte_value_i),
    .start_cluster_i(start_cluster_i),
    .strobe(strobe),
    .cluster_o(cluster_o),
    .last_o(last_o),
    .end_kind_o(end_kind_o)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("fat12_cluster_chain_walker_core regression: fail");
      $finish;
    end
  end

  // 12-bit entry n packed at byte n + n/2
  function automatic logic [CL_W-1:0] table_entry(input logic [CL_W-1:0] n);
    int off;
    off = int'(n) + int'(n[CL_W-1:1]);
    if (n[0] == 1'b0) return {fat_img[off+1][3:0], fat_img[off]};
    return {fat_img[off+1], fat_img[off][7:4]};
  endfunction

  function automatic bit entry_known(input logic [CL_W-1:0] n);
    int off;
    off = int'(n) + int'(n[CL_W-1:1]);
    return fat_known[off] && fat_known[off+1];
  endfunction

  // first cluster on the walk whose entry bytes were never written, or -1
  function automatic int first_unknown(input logic [CL_W-1:0] head);
    logic [CL_W-1:0] cur;
    logic [CL_W-1:0] e;
    int k;
    cur = head;
    for (k = 0; k < CHAIN_CAP; k++) begin
      if (!entry_known(cur)) return int'(cur);
      e = table_entry(cur);
      if (!(e >= CL_MIN && e <= CL_MAX)) return -1;
      cur = e;
    end
    return -1;
  endfunction

  // cluster reached after idx links from head
  function automatic logic [CL_W-1:0] nth_link(input logic [CL_W-1:0] head, input int idx);
    logic [CL_W-1:0] cur;
    int k;
    cur = head;
    for (k = 0; k < idx; k++) cur = table_entry(cur);
    return cur;
  endfunction

  function automatic void predict_chain(input logic [CL_W-1:0] head);
    logic [CL_W-1:0] cur;
    logic [CL_W-1:0] e;
    bit cont;
    int k;
    link_t lk;
    cur = head;
    k = 0;
    while (1) begin
      e = table_entry(cur);
      cont = (e >= CL_MIN && e <= CL_MAX);
      lk.cluster = cur;
      if (cont && k + 1 < CHAIN_CAP) begin
        lk.is_last = 1'b0;
        lk.kind = KIND_EOC;
        chain_q.push_back(lk);
        cur = e;
        k++;
      end else begin
        lk.is_last = 1'b1;
        if (e >= EOC_MIN) lk.kind = KIND_EOC;
        else if (!cont) lk.kind = KIND_BAD;
        else lk.kind = KIND_CAP;
        chain_q.push_back(lk);
        break;
      end
    end
  endfunction

  function automatic logic [CL_W-1:0] bad_code();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 12'h000;
    if (r == 1) return 12'h001;
    return CL_W'($urandom_range(12'hFF0, 12'hFF7));
  endfunction

  function automatic logic [CL_W-1:0] random_link();
    int r;
    r = $urandom_range(99);
    if (r < 50) return CL_W'($urandom_range(CL_MIN, CL_MAX));
    if (r < 80) return CL_W'($urandom_range(EOC_MIN, 12'hFFF));
    return bad_code();
  endfunction

  task automatic send_request(input logic c, input int addr, input int val, input int head);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= c;
    if (c == CMD_WRITE) begin
      byte_addr_i <= addr[ADDR_W-1:0];
      byte_value_i <= val[DATA_W-1:0];
      start_cluster_i <= CL_W'($urandom_range(4095));
    end else begin
      byte_addr_i <= ADDR_W'($urandom_range(TBL_BYTES - 1));
      byte_value_i <= DATA_W'($urandom_range(255));
      start_cluster_i <= head[CL_W-1:0];
    end
    do @(posedge clk_i); while (busy);
    n_requests++;
    if (c == CMD_WRITE) begin
      fat_img[addr] = val[DATA_W-1:0];
      fat_known[addr] = 1'b1;
    end else begin
      predict_chain(head[CL_W-1:0]);
    end
  endtask

  // rewrite one entry, keeping the neighbor nibble of the shared byte
  task automatic set_entry(input logic [CL_W-1:0] n, input logic [CL_W-1:0] v);
    int off;
    logic [3:0] keep;
    logic [DATA_W-1:0] b0;
    logic [DATA_W-1:0] b1;
    off = int'(n) + int'(n[CL_W-1:1]);
    if (n[0] == 1'b0) begin
      keep = fat_known[off+1] ? fat_img[off+1][7:4] : 4'($urandom_range(15));
      b0 = v[7:0];
      b1 = {keep, v[11:8]};
    end else begin
      keep = fat_known[off] ? fat_img[off][3:0] : 4'($urandom_range(15));
      b0 = {v[3:0], keep};
      b1 = v[11:4];
    end
    send_request(CMD_WRITE, off, int'(b0), 0);
    send_request(CMD_WRITE, off + 1, int'(b1), 0);
  endtask

  task automatic follow_chain(input logic [CL_W-1:0] head);
    int m;
    m = first_unknown(head);
    while (m >= 0) begin
      set_entry(CL_W'(m), random_link());
      m = first_unknown(head);
    end
    send_request(CMD_FOLLOW, 0, 0, int'(head));
  endtask

  task automatic build_chain(input logic [CL_W-1:0] head, input int len, input tail_e tail);
    logic [CL_W-1:0] members [$];
    bit taken [int];
    logic [CL_W-1:0] pick;
    logic [CL_W-1:0] tail_val;
    int i;
    members.push_back(head);
    taken[int'(head)] = 1'b1;
    while (members.size() < len) begin
      pick = CL_W'($urandom_range(CL_MIN, CL_MAX));
      if (!taken.exists(int'(pick))) begin
        taken[int'(pick)] = 1'b1;
        members.push_back(pick);
      end
    end
    for (i = 0; i + 1 < len; i++) set_entry(members[i], members[i+1]);
    case (tail)
      TAIL_EOC: tail_val = CL_W'($urandom_range(EOC_MIN, 12'hFFF));
      TAIL_BAD: tail_val = bad_code();
      default:  tail_val = members[$urandom_range(len - 1)];
    endcase
    set_entry(members[len-1], tail_val);
  endtask

  task automatic test_entry_codes();
    set_entry(12'h000, 12'hFFF);
    follow_chain(12'h000);
    set_entry(12'h001, 12'h000);
    follow_chain(12'h001);
    set_entry(12'hFFF, 12'hFF7);
    follow_chain(12'hFFF);
    set_entry(12'hFF0, 12'hFF8);
    follow_chain(12'hFF0);
    set_entry(12'h004, 12'h002);
    set_entry(12'h002, 12'hFF0);
    follow_chain(12'h004);
    set_entry(12'h005, 12'hFEF);
    set_entry(12'hFEF, 12'h001);
    follow_chain(12'h005);
  endtask

  task automatic test_chain_cap();
    logic [CL_W-1:0] head;
    logic [CL_W-1:0] tail_at;
    // end marker or bad entry right at the cap wins over the cap
    head = CL_W'($urandom_range(CL_MIN, CL_MAX));
    build_chain(head, CHAIN_CAP, TAIL_EOC);
    follow_chain(head);
    tail_at = nth_link(head, CHAIN_CAP - 1);
    set_entry(tail_at, bad_code());
    follow_chain(head);
    // chain still going at the cap
    set_entry(tail_at, head);
    follow_chain(head);
    // self loop and longer loop
    head = CL_W'($urandom_range(CL_MIN, CL_MAX));
    build_chain(head, 1, TAIL_LOOP);
    follow_chain(head);
    head = CL_W'($urandom_range(CL_MIN, CL_MAX));
    build_chain(head, 12, TAIL_LOOP);
    follow_chain(head);
  endtask

  task automatic test_random_chains();
    int stop_at;
    int r;
    int len;
    int t;
    tail_e tail;
    logic [CL_W-1:0] head;
    stop_at = n_requests + RANDOM_REQUESTS;
    while (n_requests < stop_at) begin
      gap_pct = (n_requests > stop_at - 150 && n_requests < stop_at - 50) ? 0 : 21;
      r = $urandom_range(99);
      if (r < 55) begin
        len = ($urandom_range(99) < 85) ? $urandom_range(1, 8) : $urandom_range(9, 24);
        t = $urandom_range(2);
        tail = (t == 0) ? TAIL_EOC : (t == 1) ? TAIL_BAD : TAIL_LOOP;
        head = CL_W'($urandom_range(CL_MIN, CL_MAX));
        build_chain(head, len, tail);
        follow_chain(head);
      end else if (r < 85) begin
        follow_chain(CL_W'($urandom_range(4095)));
      end else begin
        send_request(CMD_WRITE, int'($urandom_range(TBL_BYTES - 1)), int'($urandom_range(255)),
                     0);
      end
    end
    gap_pct = 21;
  endtask

  always @(posedge clk_i) begin
    link_t want;
    if (rst_ni && strobe === 1'b1) begin
      if (chain_q.size() == 0) begin
        $display("%0t: unexpected result expected none actual cluster %h last %b kind %0d",
                 $time, cluster_o, last_o, end_kind_o);
        n_errors++;
      end else begin
        want = chain_q.pop_front();
        if (cluster_o !== want.cluster) begin
          $display("%0t: cluster expected %h actual %h", $time, want.cluster, cluster_o);
          n_errors++;
        end
        if (last_o !== want.is_last) begin
          $display("%0t: last expected %b actual %b", $time, want.is_last, last_o);
          n_errors++;
        end
        if (end_kind_o !== want.kind) begin
          $display("%0t: end_kind expected %0d actual %0d", $time, want.kind, end_kind_o);
          n_errors++;
        end
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_entry_codes();
    test_chain_cap();
    test_random_chains();
    start <= 1'b0;
    while (chain_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("fat12_cluster_chain_walker_core regression: pass");
    end else begin
      $display("fat12_cluster_chain_walker_core regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ fat12_cluster_chain_walker_core.f @@
src/fcw_pkg.sv
src/fcw_table.sv
src/fcw_walker.sv
src/fat12_cluster_chain_walker_core.sv
sim/fat12_cluster_chain_walker_core_test.sv
